@@ sv/tkp_pkg.sv @@
// ----------------------------------------------------------------------------
// tkp_pkg
// Shared types and constants for the three-key short/long press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tkp_pkg;

    localparam int CNT_W   = 4;
    localparam int HOLD_W  = 8;
    localparam int KEY_W   = 2;
    localparam int EVT_W   = 3;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 8;

    localparam logic [CNT_W-1:0]  CNT_MAX  = 4'd15;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

    localparam logic [CNT_W-1:0]  PRESS_DB_RST   = 4'd2;
    localparam logic [CNT_W-1:0]  RELEASE_DB_RST = 4'd2;
    localparam logic [HOLD_W-1:0] LONG_LIMIT_RST = 8'd100;

    localparam logic [CFG_A_W-1:0] REG_PRESS_DB   = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_RELEASE_DB = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_LONG_LIMIT = 2'd2;

    localparam logic [KEY_W-1:0] KEY_NONE = 2'd0;
    localparam logic [KEY_W-1:0] KEY_ONE  = 2'd1;
    localparam logic [KEY_W-1:0] KEY_TWO  = 2'd2;
    localparam logic [KEY_W-1:0] KEY_THREE = 2'd3;

    localparam logic [EVT_W-1:0] EVT_NONE      = 3'd0;
    localparam logic [EVT_W-1:0] EVT_LONG_BASE = 3'd3;

    typedef enum logic [2:0] {
        MODE_LOCK_WAIT  = 3'd0,
        MODE_LOCK_CHECK = 3'd1,
        MODE_ARMED      = 3'd2,
        MODE_PRESS_WAIT = 3'd3,
        MODE_HOLDING    = 3'd4
    } mode_t;

    typedef struct packed {
        logic [CNT_W-1:0]  press_db;
        logic [CNT_W-1:0]  release_db;
        logic [HOLD_W-1:0] long_limit;
    } cfg_t;

    typedef struct packed {
        logic key1;
        logic key2;
        logic key3;
    } keys_t;

endpackage

`default_nettype wire

@@ sv/tkp_cfg.sv @@
// ----------------------------------------------------------------------------
// tkp_cfg
// Configuration register file: debounce waits and long press limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tkp_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [tkp_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [tkp_pkg::CFG_D_W-1:0]  cfg_data,
    output tkp_pkg::cfg_t                     cfg
);

    tkp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_db   <= tkp_pkg::PRESS_DB_RST;
            cfg_reg.release_db <= tkp_pkg::RELEASE_DB_RST;
            cfg_reg.long_limit <= tkp_pkg::LONG_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tkp_pkg::REG_PRESS_DB:
                    cfg_reg.press_db <= cfg_data[tkp_pkg::CNT_W-1:0];
                tkp_pkg::REG_RELEASE_DB:
                    cfg_reg.release_db <= cfg_data[tkp_pkg::CNT_W-1:0];
                tkp_pkg::REG_LONG_LIMIT:
                    cfg_reg.long_limit <= cfg_data[tkp_pkg::HOLD_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/tkp_fsm.sv @@
// ----------------------------------------------------------------------------
// tkp_fsm
// Scan state machine: key selection, debounce, hold counting, events.
// ----------------------------------------------------------------------------
`default_nettype none

module tkp_fsm (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire tkp_pkg::keys_t                keys,
    input  wire tkp_pkg::cfg_t                 cfg,
    output logic [tkp_pkg::EVT_W-1:0]          key_event
);

    tkp_pkg::mode_t                  mode_reg,   mode_next;
    logic [tkp_pkg::KEY_W-1:0]       key_reg,    key_next;
    logic [tkp_pkg::CNT_W-1:0]       dbc_reg,    dbc_next;
    logic [tkp_pkg::HOLD_W-1:0]      hold_reg,   hold_next;

    logic                            all_up;
    logic                            any_down;
    logic                            chosen_down;
    logic [tkp_pkg::KEY_W-1:0]       pick;
    logic [tkp_pkg::CNT_W-1:0]       dbc_inc;
    logic [tkp_pkg::HOLD_W-1:0]      hold_inc;

    always_comb
    begin
        all_up   = keys.key1 & keys.key2 & keys.key3;
        any_down = !all_up;
        if (!keys.key1)
            pick = tkp_pkg::KEY_ONE;
        else if (!keys.key2)
            pick = tkp_pkg::KEY_TWO;
        else
            pick = tkp_pkg::KEY_THREE;
        case (key_reg)
            tkp_pkg::KEY_ONE:   chosen_down = !keys.key1;
            tkp_pkg::KEY_TWO:   chosen_down = !keys.key2;
            tkp_pkg::KEY_THREE: chosen_down = !keys.key3;
            default:            chosen_down = 1'b0;
        endcase
        dbc_inc  = (dbc_reg < tkp_pkg::CNT_MAX) ? dbc_reg + 1'b1 : dbc_reg;
        hold_inc = (hold_reg < tkp_pkg::HOLD_MAX) ? hold_reg + 1'b1 : hold_reg;
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        key_next  = key_reg;
        dbc_next  = dbc_reg;
        hold_next = hold_reg;
        case (mode_reg)
            tkp_pkg::MODE_ARMED:
            begin
                if (any_down)
                begin
                    key_next = pick;
                    dbc_next = '0;
                    if (cfg.press_db == '0)
                    begin
                        hold_next = '0;
                        mode_next = tkp_pkg::MODE_HOLDING;
                    end
                    else
                        mode_next = tkp_pkg::MODE_PRESS_WAIT;
                end
            end
            tkp_pkg::MODE_PRESS_WAIT:
            begin
                dbc_next = dbc_inc;
                if (dbc_inc >= cfg.press_db)
                begin
                    if (chosen_down)
                    begin
                        hold_next = '0;
                        mode_next = tkp_pkg::MODE_HOLDING;
                    end
                    else
                        mode_next = tkp_pkg::MODE_ARMED;
                end
            end
            tkp_pkg::MODE_HOLDING:
            begin
                if (!chosen_down)
                    mode_next = tkp_pkg::MODE_LOCK_WAIT;
                else
                begin
                    hold_next = hold_inc;
                    if (hold_inc > cfg.long_limit)
                        mode_next = tkp_pkg::MODE_LOCK_WAIT;
                end
            end
            tkp_pkg::MODE_LOCK_CHECK:
            begin
                dbc_next = dbc_inc;
                if (dbc_inc >= cfg.release_db)
                    mode_next = all_up ? tkp_pkg::MODE_ARMED : tkp_pkg::MODE_LOCK_WAIT;
            end
            default:
            begin
                mode_next = tkp_pkg::MODE_LOCK_WAIT;
                if (all_up)
                begin
                    dbc_next = '0;
                    if (cfg.release_db == '0)
                        mode_next = tkp_pkg::MODE_ARMED;
                    else
                        mode_next = tkp_pkg::MODE_LOCK_CHECK;
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        key_event = tkp_pkg::EVT_NONE;
        case (mode_reg)
            tkp_pkg::MODE_HOLDING:
            begin
                if (!chosen_down)
                    key_event = {1'b0, key_reg};
                else if (hold_inc > cfg.long_limit)
                    key_event = {1'b0, key_reg} + tkp_pkg::EVT_LONG_BASE;
            end
            default:
                key_event = tkp_pkg::EVT_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tkp_pkg::MODE_LOCK_WAIT;
            key_reg  <= tkp_pkg::KEY_NONE;
            dbc_reg  <= '0;
            hold_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            key_reg  <= key_next;
            dbc_reg  <= dbc_next;
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/three_key_short_long_press_detector_top.sv @@
// ----------------------------------------------------------------------------
// three_key_short_long_press_detector_top
// Three-key short/long press detector with stream channels.
//
// Each input transfer is one 10 ms tick carrying three active-low key levels
// (s_tdata bit 0..2 = key 1..3). Each tick yields exactly one output transfer
// with key_event in m_tdata[2:0]: 0 none, 1-3 short press, 4-6 long press.
// A tick is first captured in the input register; the scan logic then writes
// its event into the output register, which drives output valid, once that
// register is free. Throughput is one tick per cycle while the receiver
// keeps m_tready high; the scan state advances as a tick moves from the
// input register to the output register.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more tick; s_tready drops only when both
// are full and m_tready is low.
// Configuration writes (cfg_we, cfg_addr, cfg_data) take effect on the next
// edge; write them only while no ticks are in flight.
// Reset empties both registers, loads default waits (2, 2) and limit 100,
// and starts locked, waiting for all keys released.
// ----------------------------------------------------------------------------
`default_nettype none

module three_key_short_long_press_detector_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // key1_level, key2_level, key3_level
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // key_event
    input  wire logic                          cfg_we,
    input  wire logic [tkp_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [tkp_pkg::CFG_D_W-1:0]   cfg_data
);

    tkp_pkg::cfg_t                  cfg;
    tkp_pkg::keys_t                 keys_reg;
    logic                           in_valid_reg;
    logic                           out_valid_reg;
    logic [tkp_pkg::EVT_W-1:0]      event_reg;
    logic [tkp_pkg::EVT_W-1:0]      event_next;
    logic                           out_free;
    logic                           advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    tkp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    tkp_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .keys      (keys_reg),
        .cfg       (cfg),
        .key_event (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            keys_reg.key1 <= s_tdata[0];
            keys_reg.key2 <= s_tdata[1];
            keys_reg.key3 <= s_tdata[2];
        end
        if (advance)
            event_reg <= event_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - tkp_pkg::EVT_W){1'b0}}, event_reg};

endmodule

`default_nettype wire

@@ sv/tkp_checker.sv @@
// ----------------------------------------------------------------------------
// tkp_checker
// Port-level checks for the press detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tkp_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tready,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata
);

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:3] == 5'd0 && m_tdata[2:0] != 3'd7))
        else $error("key_event out of range");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output transfer changed");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    a_no_back_to_back_events: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tdata[2:0] != 3'd0)
        |=> !(m_tvalid && m_tready && m_tdata[2:0] != 3'd0))
        else $error("events on consecutive ticks");

endmodule

bind three_key_short_long_press_detector_top tkp_checker u_tkp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
